// File: rtl/sidac_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the signed integer to decimal ascii unit
// no dependencies
package sidac_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CharWidth  = 6;
   localparam int unsigned DigitWidth = 4;
   localparam int unsigned NumDigits  = 10;

   localparam logic [CharWidth-1:0] CharZero  = 6'd48;
   localparam logic [CharWidth-1:0] CharMinus = 6'd45;
   localparam logic [CharWidth-1:0] CharNine  = 6'd57;

   // control word broadcast to every bcd cell
   typedef struct packed {
      logic clear;        // load zero into the digit
      logic bit_shift;    // add-3 adjust, then shift one bit in from below
      logic digit_shift;  // take the neighbor's digit (moves digits toward the top)
   } cell_ctl_type;

endpackage

// File: rtl/sidac_bcd_cell.sv
`timescale 1ns / 1ps
// one bcd digit cell of the double-dabble chain
// depends on sidac_pkg
module sidac_bcd_cell (
   input  logic                                clock,
   input  sidac_pkg::cell_ctl_type             ctl,
   input  logic                                carry_in,
   input  logic [sidac_pkg::DigitWidth-1:0]    digit_in,
   output logic [sidac_pkg::DigitWidth-1:0]    digit_out,
   output logic                                carry_out
);
   import sidac_pkg::*;

   logic [DigitWidth-1:0] digit_ff;
   logic [DigitWidth-1:0] digit_in_w;
   logic [DigitWidth-1:0] adj_w;

   // digits of five or more overflow on doubling, so correct by three first
   assign adj_w = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;

   always_comb begin
      digit_in_w = digit_ff;
      if (ctl.clear) begin
         digit_in_w = '0;
      end else if (ctl.bit_shift) begin
         digit_in_w = {adj_w[DigitWidth-2:0], carry_in};
      end else if (ctl.digit_shift) begin
         digit_in_w = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_w;
   end

   assign digit_out = digit_ff;
   assign carry_out = adj_w[DigitWidth-1];

endmodule

// File: rtl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// signed 32-bit integer to decimal ascii text, one character per transaction
// depends on sidac_pkg and sidac_bcd_cell
//
// usage
//   req channel: one transaction carries req_value, a two's complement integer.
//   rsp channel: the decimal text, most significant digit first, one
//   character per transaction; a leading '-' for negative values, no leading
//   zeros, zero prints as '0'. rsp_last_char marks the final character.
// timing
//   after acceptance the magnitude is shifted into a chain of ten bcd cells,
//   one bit per cycle in 32 steps (double dabble). leading zero digits are
//   then dropped one per cycle by shifting the digit chain up (at most
//   nine of them). each character then leaves the output register at one
//   per cycle while rsp is not stalled, the digit chain moving up one cell
//   per character. one number is worked on at a time; req_stall is high
//   until the last character has been loaded into the output register.
// reset
//   synchronous, active high: returns to idle and drops rsp_valid.
// stall
//   a stalled rsp holds its character; the digit chain waits with it.
module signed_int_to_decimal_ascii_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [sidac_pkg::ValueWidth-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sidac_pkg::CharWidth-1:0]    rsp_ascii_char,
   output logic                               rsp_last_char
);
   import sidac_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   localparam int unsigned BitCntWidth = $clog2(ValueWidth);
   localparam int unsigned RemWidth    = $clog2(NumDigits + 1);
   localparam int unsigned TopCell     = NumDigits - 1;

   // control and payload registers
   state_type                state_ff, state_in;
   logic [ValueWidth-1:0]    mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [BitCntWidth-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [RemWidth-1:0]      rem_ff, rem_in;       // digits still in the chain
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]     rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctl_type             ctl_w;
   logic [DigitWidth-1:0]    digit_w [NumDigits];
   logic                     carry_w [NumDigits];
   logic                     req_take_w;
   logic                     out_free_w;
   logic [DigitWidth-1:0]    top_digit_w;

   assign req_take_w  = req_valid && (state_ff == ST_IDLE);
   assign out_free_w  = !rsp_valid_ff || !rsp_stall;
   assign top_digit_w = digit_w[TopCell];

   // chain of bcd cells: bits carry upward, digits move upward on zero skipping and emission
   for (genvar gi = 0; gi < NumDigits; gi++) begin : g_cell
      logic                  cin_w;
      logic [DigitWidth-1:0] din_w;
      if (gi == 0) begin : g_bottom
         assign cin_w = mag_ff[ValueWidth-1];
         assign din_w = '0;
      end else begin : g_upper
         assign cin_w = carry_w[gi-1];
         assign din_w = digit_w[gi-1];
      end
      sidac_bcd_cell u_cell (
         .clock     (clock),
         .ctl       (ctl_w),
         .carry_in  (cin_w),
         .digit_in  (din_w),
         .digit_out (digit_w[gi]),
         .carry_out (carry_w[gi])
      );
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bit_cnt_in   = bit_cnt_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctl_w        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take_w) begin
               // most negative value negates to itself, read as unsigned 2^31
               neg_in     = req_value[ValueWidth-1];
               mag_in     = req_value[ValueWidth-1] ? (~req_value + 1'b1) : req_value;
               bit_cnt_in = '0;
               rem_in     = RemWidth'(NumDigits);
               ctl_w.clear = 1'b1;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctl_w.bit_shift = 1'b1;
            mag_in     = {mag_ff[ValueWidth-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BitCntWidth'(ValueWidth - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, but always keep the final digit
            if ((top_digit_w == '0) && (rem_ff > RemWidth'(1))) begin
               ctl_w.digit_shift = 1'b1;
               rem_in = rem_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free_w) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CharMinus;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free_w) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CharZero + {{(CharWidth-DigitWidth){1'b0}}, top_digit_w};
               rsp_last_in  = (rem_ff == RemWidth'(1));
               ctl_w.digit_shift = 1'b1;
               rem_in = rem_ff - 1'b1;
               if (rem_ff == RemWidth'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
         bit_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         bit_cnt_ff   <= bit_cnt_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;

   // the ten-digit chain never overflows for a 32-bit magnitude
   a_no_chain_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) |-> !carry_w[TopCell])
      else $error("bcd chain overflow out of the top cell");

   // digit count is untouched while bits are shifting in
   a_rem_during_convert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) |-> (rem_ff == RemWidth'(NumDigits)))
      else $error("digit count changed during conversion");

   // characters are only '-' or a decimal digit
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_char_ff == CharMinus) ||
                        ((rsp_char_ff >= CharZero) && (rsp_char_ff <= CharNine))))
      else $error("character out of range");

   // a sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_char_ff == CharMinus)) |-> !rsp_last_ff)
      else $error("sign flagged as last character");

   // at least one digit remains whenever a number is in flight past conversion
   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SKIP) || (state_ff == ST_SIGN) || (state_ff == ST_EMIT))
      |-> (rem_ff != '0))
      else $error("digit count ran out early");

endmodule
